// ----- hdl/vzwp_pkg.sv -----
// vzwp_pkg: shared types and constants for the zoom window placer
// no dependencies
`default_nettype none
package vzwp_pkg;
  localparam int unsigned DIM_BITS = 12;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_MODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_W_720   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_H_720   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_W_1080  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_H_1080  = 3'd4;
  localparam int unsigned MAX_ZOOM = 5;
  localparam int unsigned OW = 11;
  localparam int unsigned QW = 23;
endpackage
`default_nettype wire

// ----- hdl/vzwp_front.sv -----
// vzwp_front: zoom classification, crop window and fit area selection
// depends on vzwp_pkg
`default_nettype none
module vzwp_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  output logic                               in_rdy,
  input  wire logic [vzwp_pkg::DIM_BITS-1:0] image_width,
  input  wire logic [vzwp_pkg::DIM_BITS-1:0] image_height,
  input  wire logic [2:0]                    requested_zoom,
  input  wire logic                          flip_x,
  input  wire logic                          mode,
  input  wire logic [11:0]                   min_w,
  input  wire logic [11:0]                   min_h,
  output logic                               f_vld_r,
  input  wire logic                          f_rdy,
  output logic [2:0]                         kmax_r,
  output logic [11:0]                        sp_r,
  output logic [11:0]                        sl_r,
  output logic [11:0]                        el_r,
  output logic [12:0]                        sw_r,
  output logic [11:0]                        sh_r,
  output logic                               mode_r,
  output logic                               small_r,
  output logic                               flip_r
);
  localparam int unsigned DIM_BITS = vzwp_pkg::DIM_BITS;
  localparam int unsigned TW = DIM_BITS + 6;
  logic [2:0] kmax, z;
  logic [DIM_BITS-1:0] cw, ch, sp, hw, hh;
  logic [DIM_BITS:0] sw;
  logic [DIM_BITS-1:0] sh, sl, el;
  logic [2:0] kmax_nxt;

  assign in_rdy = !f_vld_r || f_rdy;

  always_comb begin
    kmax = 3'd0;
    for (int k = 1; k <= vzwp_pkg::MAX_ZOOM; k++) begin
      if ((TW'(image_width) >= (TW'(min_w) << k)) &&
          (TW'(image_height) >= (TW'(min_h) << k)))
        kmax = 3'(k);
    end
    if (requested_zoom > 3'(vzwp_pkg::MAX_ZOOM)) z = 3'd0;
    else z = (requested_zoom < kmax) ? requested_zoom : kmax;
    cw = image_width >> z;
    ch = image_height >> z;
    hw = image_width >> 1;
    hh = image_height >> 1;
    if (z == 3'd0) begin
      sw = {1'b0, image_width};
      sh = image_height;
      sp = '0;
      sl = DIM_BITS'(1);
      el = image_height;
    end else begin
      sw = {1'b0, cw} + (DIM_BITS+1)'(cw[0]);
      sh = ch;
      if (hw >= (cw >> 1) + DIM_BITS'(1)) sp = hw - (cw >> 1) - DIM_BITS'(1);
      else sp = '0;
      sp[0] = 1'b1;
      sl = hh - (ch >> 1) + DIM_BITS'(1);
      el = hh + (ch >> 1) + DIM_BITS'(ch[0]);
    end
    if (sw == '0) sw = (DIM_BITS+1)'(1);
    if (sh == '0) sh = DIM_BITS'(1);
    kmax_nxt = kmax;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (in_rdy) begin
      f_vld_r <= in_vld;
    end
    if (in_vld && in_rdy) begin
      kmax_r  <= kmax_nxt;
      sp_r    <= 12'(sp);
      sl_r    <= 12'(sl);
      el_r    <= 12'(el);
      sw_r    <= 13'(sw);
      sh_r    <= 12'(sh);
      mode_r  <= mode;
      small_r <= mode ? (sh < DIM_BITS'(128)) : (sh < DIM_BITS'(64));
      flip_r  <= flip_x;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    f_vld_r && !f_rdy |=> f_vld_r && $stable(sw_r) && $stable(sh_r))
    else $error("front result lost while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    f_vld_r |-> sw_r != '0 && sh_r != '0)
    else $error("zero scaler size");
  assert property (@(posedge clk) disable iff (!rst_n)
    f_vld_r && kmax_r != 3'd0 |-> kmax_r <= 3'(vzwp_pkg::MAX_ZOOM))
    else $error("zoom code out of range");
endmodule
`default_nettype wire

// ----- hdl/vzwp_div.sv -----
// vzwp_div: pipelined restoring divider, one quotient bit per stage
// depends on vzwp_pkg
`default_nettype none
module vzwp_div (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [vzwp_pkg::QW-1:0] num,
  input  wire logic [12:0]             den,
  output logic [vzwp_pkg::OW-1:0]      quo
);
  localparam int unsigned QB = vzwp_pkg::OW + 1;
  localparam int unsigned RW = 14;
  logic [RW-1:0] rem_c [QB];
  logic [QB-1:0] num_c [QB];
  logic [12:0]   den_c [QB];
  logic [QB-1:0] q_c   [QB];
  logic [RW-1:0] rem_r [1:QB-1];
  logic [QB-1:0] num_r [1:QB-1];
  logic [12:0]   den_r [1:QB-1];
  logic [QB-1:0] q_r   [1:QB];
  logic [RW-1:0] trial [QB];
  logic [RW:0]   diff  [QB];

  always_comb begin
    rem_c[0] = RW'(num[vzwp_pkg::QW-1:QB]);
    num_c[0] = num[QB-1:0];
    den_c[0] = den;
    q_c[0]   = '0;
    for (int i = 1; i < QB; i++) begin
      rem_c[i] = rem_r[i];
      num_c[i] = num_r[i];
      den_c[i] = den_r[i];
      q_c[i]   = q_r[i];
    end
    for (int i = 0; i < QB; i++) begin
      trial[i] = {rem_c[i][RW-2:0], num_c[i][QB-1-i]};
      diff[i]  = {1'b0, trial[i]} - {2'b0, den_c[i]};
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) q_r[i+1] <= {q_c[i][QB-2:0], ~diff[i][RW]};
    end
    if (i < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= diff[i][RW] ? trial[i] : diff[i][RW-1:0];
          num_r[i+1] <= num_c[i];
          den_r[i+1] <= den_c[i];
        end
      end
    end
  end

  assign quo = q_r[QB][vzwp_pkg::OW-1:0];
endmodule
`default_nettype wire

// ----- hdl/vzwp_back.sv -----
// vzwp_back: fit into the output area and link placement, pipelined
// depends on vzwp_pkg and vzwp_div
`default_nettype none
module vzwp_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        b_vld,
  input  wire logic [2:0]  kmax,
  input  wire logic [11:0] sp,
  input  wire logic [11:0] sl,
  input  wire logic [11:0] el,
  input  wire logic [12:0] sw,
  input  wire logic [11:0] sh,
  input  wire logic        mode,
  input  wire logic        small_img,
  input  wire logic        flip,
  output logic             o_vld,
  output logic [129:0]     o_data
);
  localparam int unsigned LAT = vzwp_pkg::OW + 1;
  localparam int unsigned FW = 3 + 12*3 + 13 + 12;
  localparam int unsigned PW = FW + 11*2 + 4;
  logic [10:0] mw, mh;
  logic [vzwp_pkg::QW-1:0] a, b;
  logic wide;
  logic [vzwp_pkg::QW-1:0] num;
  logic [12:0] den;
  logic [PW-1:0] p_r [LAT];
  logic [LAT-1:0] v_r;
  logic [10:0] quo, ow, oh, mw_d, mh_d, ox, oy, first, hs, he, vs, add;
  logic [PW-1:0] pin, pout;
  logic wide_d, mode_d, small_d, flip_d;

  always_comb begin
    unique case ({mode, small_img})
      2'b00:   begin mw = 11'd1270; mh = 11'd720; end
      2'b01:   begin mw = 11'd640;  mh = 11'd360; end
      2'b10:   begin mw = 11'd1910; mh = 11'd1080; end
      default: begin mw = 11'd960;  mh = 11'd540; end
    endcase
    a = vzwp_pkg::QW'(mw) * vzwp_pkg::QW'(sh);
    b = vzwp_pkg::QW'(mh) * vzwp_pkg::QW'(sw);
    wide = a < b;
    num = wide ? a : b;
    den = wide ? sw : 13'(sh);
    pin = {kmax, sp, sl, el, sw, sh, mw, mh, wide, flip, mode, small_img};
  end

  vzwp_div u_div (.clk(clk), .en(en), .num(num), .den(den), .quo(quo));

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= pin;
      for (int i = 1; i < LAT; i++) p_r[i] <= p_r[i-1];
    end
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], b_vld};
  end

  always_comb begin
    pout = p_r[LAT-1];
    mw_d = pout[25:15];
    mh_d = pout[14:4];
    wide_d = pout[3];
    flip_d = pout[2];
    mode_d = pout[1];
    small_d = pout[0];
    ow = wide_d ? mw_d : quo;
    oh = wide_d ? quo : mh_d;
    if (oh < 11'd31) oh = 11'd31;
    first = mode_d ? 11'd42 : 11'd26;
    ox = small_d ? (mode_d ? 11'd480 : 11'd320) : 11'd0;
    oy = small_d ? (mode_d ? 11'd270 : 11'd180) : 11'd0;
    vs = ((mh_d - oh) >> 1) + first + oy;
    hs = ((mw_d - ow) >> 1) + 11'd1;
    he = hs + ow - 11'd1;
    if (!flip_d) add = hs[0] ? 11'd4 : 11'd3;
    else add = he[0] ? 11'd3 : 11'd4;
    o_data = {pout[PW-1:26], ow, oh, hs + add + ox, he + add + ox, vs,
              vs + oh - 11'd1};
  end

  assign o_vld = v_r[LAT-1];
endmodule
`default_nettype wire

// ----- hdl/video_zoom_window_placer.sv -----
// video_zoom_window_placer: top level with config registers and result queue
// depends on vzwp_pkg, vzwp_front, vzwp_back
//
// input channel: push/full carrying the image size, requested zoom and flip
// result channel: empty/pop, one result per request, in order
// config channel: cfg_valid/cfg_ready, index 0 mode, 1..4 zoom thresholds
// a request enters every cycle while full is low; its result passes the
// front register (loaded at acceptance), a 12 stage divider pipeline and
// one output register fed by bypass or the queue memory to the out ports
// throughput is one request per cycle while full is low, set by the pipelined divider
// the pipeline advances only while at most 16 results wait; a stalled
// receiver lets 17 results collect, then the pipeline holds and full rises
// full falls again in the same cycle that the count is back at 16
// reset empties the pipeline and queue and loads the register defaults
`default_nettype none
module video_zoom_window_placer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [vzwp_pkg::DIM_BITS-1:0] in_image_width,
  input  wire logic [vzwp_pkg::DIM_BITS-1:0] in_image_height,
  input  wire logic [2:0]                    in_requested_zoom,
  input  wire logic                          in_flip_x,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [2:0]                         out_max_zoom_code,
  output logic [11:0]                        out_crop_start_pixel,
  output logic [11:0]                        out_crop_start_line,
  output logic [11:0]                        out_crop_stop_line,
  output logic [12:0]                        out_scaler_width,
  output logic [11:0]                        out_scaler_height,
  output logic [10:0]                        out_out_width,
  output logic [10:0]                        out_out_height,
  output logic [10:0]                        out_h_start,
  output logic [10:0]                        out_h_stop,
  output logic [10:0]                        out_v_start,
  output logic [10:0]                        out_v_stop,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [11:0]                   cfg_data
);
  localparam int unsigned DEPTH = 32;
  localparam int unsigned AW = 5;
  localparam int unsigned INFL = 16;
  localparam int unsigned DW = 130;
  logic mode_r;
  logic [11:0] minw720_r, minh720_r, minw1080_r, minh1080_r;
  logic f_vld, in_rdy, en, o_vld;
  logic [2:0] kmax;
  logic [11:0] sp, sl, el, sh;
  logic [12:0] sw;
  logic fmode, fsmall, fflip;
  logic [DW-1:0] o_data;
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_r;
  logic rd_vld_r;
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r, cnt_nxt;
  logic push_ok, pop_ok, take, ram_empty, ram_wr, ram_rd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      minw720_r <= 12'd40; minh720_r <= 12'd32;
      minw1080_r <= 12'd40; minh1080_r <= 12'd32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vzwp_pkg::REG_OUTPUT_MODE: mode_r <= cfg_data[0];
        vzwp_pkg::REG_MIN_W_720:   minw720_r <= cfg_data;
        vzwp_pkg::REG_MIN_H_720:   minh720_r <= cfg_data;
        vzwp_pkg::REG_MIN_W_1080:  minw1080_r <= cfg_data;
        vzwp_pkg::REG_MIN_H_1080:  minh1080_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = (cnt_r <= (AW+1)'(DEPTH - INFL));
  assign in_full = !(en && in_rdy);

  vzwp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(in_push && !in_full), .in_rdy(in_rdy),
    .image_width(in_image_width), .image_height(in_image_height),
    .requested_zoom(in_requested_zoom), .flip_x(in_flip_x),
    .mode(mode_r), .min_w(mode_r ? minw1080_r : minw720_r),
    .min_h(mode_r ? minh1080_r : minh720_r),
    .f_vld_r(f_vld), .f_rdy(en), .kmax_r(kmax), .sp_r(sp), .sl_r(sl),
    .el_r(el), .sw_r(sw), .sh_r(sh), .mode_r(fmode), .small_r(fsmall),
    .flip_r(fflip));

  vzwp_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .b_vld(f_vld), .kmax(kmax), .sp(sp),
    .sl(sl), .el(el), .sw(sw), .sh(sh), .mode(fmode), .small_img(fsmall),
    .flip(fflip), .o_vld(o_vld), .o_data(o_data));

  assign push_ok = o_vld && en;
  assign pop_ok = out_pop && !out_empty;
  assign cnt_nxt = cnt_r + (AW+1)'(push_ok) - (AW+1)'(pop_ok);

  // output register free this cycle, memory holds everything behind it
  assign take = !rd_vld_r || pop_ok;
  assign ram_empty = (cnt_r == (AW+1)'(rd_vld_r));
  assign ram_rd = take && !ram_empty;
  assign ram_wr = push_ok && !(take && ram_empty);

  always_ff @(posedge clk) begin
    if (ram_wr) mem[wp_r] <= o_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (take) begin
      rd_vld_r <= !ram_empty || push_ok;
    end
    if (ram_rd) rd_r <= mem[rp_r];
    else if (take && push_ok) rd_r <= o_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (ram_wr) wp_r <= wp_r + AW'(1);
      if (ram_rd) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  assign out_empty = !rd_vld_r;
  assign out_max_zoom_code    = rd_r[129:127];
  assign out_crop_start_pixel = rd_r[126:115];
  assign out_crop_start_line  = rd_r[114:103];
  assign out_crop_stop_line   = rd_r[102:91];
  assign out_scaler_width     = rd_r[90:78];
  assign out_scaler_height    = rd_r[77:66];
  assign out_out_width        = rd_r[65:55];
  assign out_out_height       = rd_r[54:44];
  assign out_h_start          = rd_r[43:33];
  assign out_h_stop           = rd_r[32:22];
  assign out_v_start          = rd_r[21:11];
  assign out_v_stop           = rd_r[10:0];

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> in_full)
    else $error("request taken while pipeline held");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_empty |-> !pop_ok)
    else $error("pop from empty queue");
endmodule
`default_nettype wire
